@@ hdl/qfpu_pkg.sv @@
// Shared constants and opcodes for the quaternion fixed-point unit.
package qfpu_pkg;

    localparam int FRAC_BITS_DEF = 12;
    localparam int WORD_BITS_DEF = 32;
    localparam int FIELD_W       = 32;
    localparam int CMD_W         = 3;
    localparam int NUM_COMP      = 4;
    localparam int NUM_LANES     = 16;
    localparam int NUM_RES       = 9;

    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SCALE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NORM  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ROT   = 3'd5;

endpackage

@@ hdl/qfpu_opsel.sv @@
// Operand select stage: routes quaternion components to the multiplier lanes and forms add/sub results directly.
module qfpu_opsel #(
    parameter int WORD_BITS = qfpu_pkg::WORD_BITS_DEF
) (
    input  logic                                                aclk,
    input  logic                                                en,
    input  logic [qfpu_pkg::CMD_W-1:0]                          cmd,
    input  logic [qfpu_pkg::NUM_COMP-1:0][WORD_BITS-1:0]        a,
    input  logic [qfpu_pkg::NUM_COMP-1:0][WORD_BITS-1:0]        b,
    input  logic [WORD_BITS-1:0]                                sc,
    output logic [qfpu_pkg::NUM_LANES-1:0][WORD_BITS-1:0]       op_a_reg,
    output logic [qfpu_pkg::NUM_LANES-1:0][WORD_BITS-1:0]       op_b_reg,
    output logic [qfpu_pkg::NUM_COMP-1:0][WORD_BITS-1:0]        dir_reg
);

    logic [qfpu_pkg::NUM_LANES-1:0][WORD_BITS-1:0] op_a_next;
    logic [qfpu_pkg::NUM_LANES-1:0][WORD_BITS-1:0] op_b_next;
    logic [qfpu_pkg::NUM_COMP-1:0][WORD_BITS-1:0]  dir_next;

    always_comb begin
        op_a_next = '0;
        op_b_next = '0;
        dir_next  = '0;
        case (cmd)
            qfpu_pkg::CMD_ADD: begin
                for (int i = 0; i < qfpu_pkg::NUM_COMP; i++) begin
                    dir_next[i] = a[i] + b[i];
                end
            end
            qfpu_pkg::CMD_SUB: begin
                for (int i = 0; i < qfpu_pkg::NUM_COMP; i++) begin
                    dir_next[i] = a[i] - b[i];
                end
            end
            qfpu_pkg::CMD_MUL: begin
                // lane 4*i+j carries a[i]*b[j]
                for (int i = 0; i < qfpu_pkg::NUM_COMP; i++) begin
                    for (int j = 0; j < qfpu_pkg::NUM_COMP; j++) begin
                        op_a_next[i*qfpu_pkg::NUM_COMP+j] = a[i];
                        op_b_next[i*qfpu_pkg::NUM_COMP+j] = b[j];
                    end
                end
            end
            qfpu_pkg::CMD_SCALE: begin
                for (int i = 0; i < qfpu_pkg::NUM_COMP; i++) begin
                    op_a_next[i] = sc;
                    op_b_next[i] = a[i];
                end
            end
            qfpu_pkg::CMD_NORM: begin
                for (int i = 0; i < qfpu_pkg::NUM_COMP; i++) begin
                    op_a_next[i] = a[i];
                    op_b_next[i] = a[i];
                end
            end
            qfpu_pkg::CMD_ROT: begin
                // lanes: xx yy zz xy yz xz wx wy wz
                op_a_next[0] = a[1]; op_b_next[0] = a[1];
                op_a_next[1] = a[2]; op_b_next[1] = a[2];
                op_a_next[2] = a[3]; op_b_next[2] = a[3];
                op_a_next[3] = a[1]; op_b_next[3] = a[2];
                op_a_next[4] = a[2]; op_b_next[4] = a[3];
                op_a_next[5] = a[1]; op_b_next[5] = a[3];
                op_a_next[6] = a[0]; op_b_next[6] = a[1];
                op_a_next[7] = a[0]; op_b_next[7] = a[2];
                op_a_next[8] = a[0]; op_b_next[8] = a[3];
            end
            default: begin
                op_a_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_a_reg <= op_a_next;
            op_b_reg <= op_b_next;
            dir_reg  <= dir_next;
        end
    end

endmodule

@@ hdl/qfpu_fmul.sv @@
// Bank of registered fixed-point multipliers with round-half-up and wrap.
module qfpu_fmul #(
    parameter int WORD_BITS = qfpu_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = qfpu_pkg::FRAC_BITS_DEF,
    parameter int LANES     = qfpu_pkg::NUM_LANES
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic [LANES-1:0][WORD_BITS-1:0]  x,
    input  logic [LANES-1:0][WORD_BITS-1:0]  y,
    output logic [LANES-1:0][WORD_BITS-1:0]  p_reg
);

    localparam int PW = 2 * WORD_BITS;
    localparam int EW = (PW > FRAC_BITS + WORD_BITS) ? PW : FRAC_BITS + WORD_BITS;
    localparam logic signed [EW-1:0] HALF = EW'(1) << (FRAC_BITS - 1);

    logic [LANES-1:0][WORD_BITS-1:0] p_next;

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        logic signed [PW-1:0] prod;
        logic signed [EW-1:0] rnd;

        assign prod      = $signed(x[i]) * $signed(y[i]);
        assign rnd       = EW'(prod) + HALF;
        assign p_next[i] = rnd[FRAC_BITS+WORD_BITS-1:FRAC_BITS];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p_next;
        end
    end

endmodule

@@ hdl/qfpu_combine.sv @@
// Sum stage: folds lane products into the per-operation result terms; add/sub results pass through.
module qfpu_combine #(
    parameter int WORD_BITS = qfpu_pkg::WORD_BITS_DEF
) (
    input  logic                                           aclk,
    input  logic                                           en,
    input  logic [qfpu_pkg::CMD_W-1:0]                     cmd,
    input  logic [qfpu_pkg::NUM_LANES-1:0][WORD_BITS-1:0]  p,
    input  logic [qfpu_pkg::NUM_COMP-1:0][WORD_BITS-1:0]   dir,
    output logic [qfpu_pkg::NUM_RES-1:0][WORD_BITS-1:0]    sum_reg
);

    logic [qfpu_pkg::NUM_RES-1:0][WORD_BITS-1:0] sum_next;

    always_comb begin
        sum_next = '0;
        case (cmd)
            qfpu_pkg::CMD_ADD, qfpu_pkg::CMD_SUB: begin
                for (int i = 0; i < qfpu_pkg::NUM_COMP; i++) begin
                    sum_next[i] = dir[i];
                end
            end
            qfpu_pkg::CMD_MUL: begin
                // cross terms carry the negated sign, i.e. b times a
                sum_next[0] = p[0] - p[5] - p[10] - p[15];
                sum_next[1] = p[1] + p[4] - p[11] + p[14];
                sum_next[2] = p[2] + p[7] + p[8] - p[13];
                sum_next[3] = p[3] - p[6] + p[9] + p[12];
            end
            qfpu_pkg::CMD_SCALE: begin
                for (int i = 0; i < qfpu_pkg::NUM_COMP; i++) begin
                    sum_next[i] = p[i];
                end
            end
            qfpu_pkg::CMD_NORM: begin
                sum_next[0] = p[0] + p[1] + p[2] + p[3];
            end
            qfpu_pkg::CMD_ROT: begin
                sum_next[0] = p[1] + p[2];
                sum_next[1] = p[3] - p[8];
                sum_next[2] = p[5] + p[7];
                sum_next[3] = p[3] + p[8];
                sum_next[4] = p[2] + p[0];
                sum_next[5] = p[4] - p[6];
                sum_next[6] = p[5] - p[7];
                sum_next[7] = p[4] + p[6];
                sum_next[8] = p[1] + p[0];
            end
            default: begin
                sum_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
        end
    end

endmodule

@@ hdl/quaternion_fixed_point_unit.sv @@
// Top level of the pipelined quaternion fixed-point unit.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  s_      | in        | s_valid / s_ready  | s_cmd, s_a_w..s_a_z, s_b_w..s_b_z, s_scale
//  m_      | out       | m_valid / m_ready  | m_r0..m_r8
//
// One transaction per cycle sustained while m_ready holds; on its way to m_valid an accepted
// transaction passes operand select, lane multiply, sum, doubling multiply and output register.
// The two multiplier stages set the clock; each holds one 32x32 multiply per lane.
// Every stage has its own valid bit and loads whenever it is empty or its
// successor loads, so bubbles collapse and a stall holds items in place.
// aresetn is synchronous and clears only the valid bits.
module quaternion_fixed_point_unit #(
    parameter int FRAC_BITS = qfpu_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = qfpu_pkg::WORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [qfpu_pkg::CMD_W-1:0]          s_cmd,
    input  logic signed [qfpu_pkg::FIELD_W-1:0] s_a_w,
    input  logic signed [qfpu_pkg::FIELD_W-1:0] s_a_x,
    input  logic signed [qfpu_pkg::FIELD_W-1:0] s_a_y,
    input  logic signed [qfpu_pkg::FIELD_W-1:0] s_a_z,
    input  logic signed [qfpu_pkg::FIELD_W-1:0] s_b_w,
    input  logic signed [qfpu_pkg::FIELD_W-1:0] s_b_x,
    input  logic signed [qfpu_pkg::FIELD_W-1:0] s_b_y,
    input  logic signed [qfpu_pkg::FIELD_W-1:0] s_b_z,
    input  logic signed [qfpu_pkg::FIELD_W-1:0] s_scale,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [qfpu_pkg::FIELD_W-1:0] m_r0,
    output logic signed [qfpu_pkg::FIELD_W-1:0] m_r1,
    output logic signed [qfpu_pkg::FIELD_W-1:0] m_r2,
    output logic signed [qfpu_pkg::FIELD_W-1:0] m_r3,
    output logic signed [qfpu_pkg::FIELD_W-1:0] m_r4,
    output logic signed [qfpu_pkg::FIELD_W-1:0] m_r5,
    output logic signed [qfpu_pkg::FIELD_W-1:0] m_r6,
    output logic signed [qfpu_pkg::FIELD_W-1:0] m_r7,
    output logic signed [qfpu_pkg::FIELD_W-1:0] m_r8
);

    localparam int NSTG  = 5;
    localparam int NRES  = qfpu_pkg::NUM_RES;
    localparam int NCOMP = qfpu_pkg::NUM_COMP;
    localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(64'd1 << FRAC_BITS);
    localparam logic [WORD_BITS-1:0] TWO = WORD_BITS'(64'd2 << FRAC_BITS);

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] ld;

    logic [qfpu_pkg::CMD_W-1:0] cmd0_reg, cmd1_reg, cmd2_reg, cmd3_reg;

    logic [NCOMP-1:0][WORD_BITS-1:0]              a_vec, b_vec;
    logic [qfpu_pkg::NUM_LANES-1:0][WORD_BITS-1:0] op_a, op_b, prod;
    logic [NCOMP-1:0][WORD_BITS-1:0]              dir0, dir1_reg;
    logic [NRES-1:0][WORD_BITS-1:0]               sum2;
    logic [NRES-1:0][WORD_BITS-1:0]               sum3_reg;
    logic [NRES-1:0][WORD_BITS-1:0]               dbl3;
    logic [NRES-1:0][WORD_BITS-1:0]               two_vec;
    logic [NRES-1:0][WORD_BITS-1:0]               res;
    logic [NRES-1:0][qfpu_pkg::FIELD_W-1:0]       r_reg, r_next;

    // load chain: a stage loads when it is empty or its successor loads
    always_comb begin
        ld[NSTG-1] = !vld_reg[NSTG-1] || m_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            ld[k] = !vld_reg[k] || ld[k+1];
        end
        vld_next[0] = ld[0] ? s_valid : vld_reg[0];
        for (int k = 1; k < NSTG; k++) begin
            vld_next[k] = ld[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = ld[0];
    assign m_valid = vld_reg[NSTG-1];

    assign a_vec[0] = s_a_w[WORD_BITS-1:0];
    assign a_vec[1] = s_a_x[WORD_BITS-1:0];
    assign a_vec[2] = s_a_y[WORD_BITS-1:0];
    assign a_vec[3] = s_a_z[WORD_BITS-1:0];
    assign b_vec[0] = s_b_w[WORD_BITS-1:0];
    assign b_vec[1] = s_b_x[WORD_BITS-1:0];
    assign b_vec[2] = s_b_y[WORD_BITS-1:0];
    assign b_vec[3] = s_b_z[WORD_BITS-1:0];

    qfpu_opsel #(
        .WORD_BITS (WORD_BITS)
    ) u_opsel (
        .aclk     (aclk),
        .en       (ld[0]),
        .cmd      (s_cmd),
        .a        (a_vec),
        .b        (b_vec),
        .sc       (s_scale[WORD_BITS-1:0]),
        .op_a_reg (op_a),
        .op_b_reg (op_b),
        .dir_reg  (dir0)
    );

    qfpu_fmul #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .LANES     (qfpu_pkg::NUM_LANES)
    ) u_mul_lane (
        .aclk  (aclk),
        .en    (ld[1]),
        .x     (op_a),
        .y     (op_b),
        .p_reg (prod)
    );

    qfpu_combine #(
        .WORD_BITS (WORD_BITS)
    ) u_combine (
        .aclk    (aclk),
        .en      (ld[2]),
        .cmd     (cmd1_reg),
        .p       (prod),
        .dir     (dir1_reg),
        .sum_reg (sum2)
    );

    always_comb begin
        for (int i = 0; i < NRES; i++) begin
            two_vec[i] = TWO;
        end
    end

    qfpu_fmul #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .LANES     (NRES)
    ) u_mul_dbl (
        .aclk  (aclk),
        .en    (ld[3]),
        .x     (sum2),
        .y     (two_vec),
        .p_reg (dbl3)
    );

    // sideband payload that travels beside the lane registers
    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            cmd0_reg <= s_cmd;
        end
        if (ld[1]) begin
            cmd1_reg <= cmd0_reg;
            dir1_reg <= dir0;
        end
        if (ld[2]) begin
            cmd2_reg <= cmd1_reg;
        end
        if (ld[3]) begin
            cmd3_reg <= cmd2_reg;
            sum3_reg <= sum2;
        end
        if (ld[4]) begin
            r_reg <= r_next;
        end
    end

    // rotation diagonal is one minus the doubled term
    always_comb begin
        for (int i = 0; i < NRES; i++) begin
            if (cmd3_reg == qfpu_pkg::CMD_ROT) begin
                if (i == 0 || i == 4 || i == 8) begin
                    res[i] = ONE - dbl3[i];
                end else begin
                    res[i] = dbl3[i];
                end
            end else begin
                res[i] = sum3_reg[i];
            end
            r_next[i] = qfpu_pkg::FIELD_W'($signed(res[i]));
        end
    end

    assign m_r0 = r_reg[0];
    assign m_r1 = r_reg[1];
    assign m_r2 = r_reg[2];
    assign m_r3 = r_reg[3];
    assign m_r4 = r_reg[4];
    assign m_r5 = r_reg[5];
    assign m_r6 = r_reg[6];
    assign m_r7 = r_reg[7];
    assign m_r8 = r_reg[8];

endmodule

@@ hdl/qfpu_checker.sv @@
// Port-level checks for the quaternion unit, bound to the top level.
module qfpu_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [qfpu_pkg::FIELD_W-1:0] m_r0,
    input logic [qfpu_pkg::FIELD_W-1:0] m_r4,
    input logic [qfpu_pkg::FIELD_W-1:0] m_r8
);

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // input can only back up when every stage is full and the output is stalled
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low while pipeline can advance");

    // with the output draining, an accepted transaction must reach m_valid
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("transaction did not reach the output in time");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_r0) && $stable(m_r4) && $stable(m_r8)))
        else $error("stalled result changed");

endmodule

bind quaternion_fixed_point_unit qfpu_checker u_qfpu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_r0    (m_r0),
    .m_r4    (m_r4),
    .m_r8    (m_r8)
);

@@ tb/sv/qfpu_tb_pkg.sv @@
`timescale 1ns / 1ps
// Types, stimulus helpers, Q20.12 result predictor and scoreboard for the quaternion unit bench.
package qfpu_tb_pkg;

    typedef logic signed [qfpu_pkg::FIELD_W-1:0] word_t;

    // Operand set of one input transaction.
    typedef struct packed {
        logic [qfpu_pkg::CMD_W-1:0] cmd;
        word_t                      aw;
        word_t                      ax;
        word_t                      ay;
        word_t                      az;
        word_t                      bw;
        word_t                      bx;
        word_t                      by;
        word_t                      bz;
        word_t                      sc;
    } quat_op_t;

    // Result fields r0..r8, element i holds r<i>.
    typedef logic [qfpu_pkg::NUM_RES-1:0][qfpu_pkg::FIELD_W-1:0] quat_res_t;

    // Opcodes without a function; they return all zeros.
    localparam logic [qfpu_pkg::CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [qfpu_pkg::CMD_W-1:0] CMD_SPARE7 = 3'd7;

    localparam int    FRAC     = qfpu_pkg::FRAC_BITS_DEF;
    localparam word_t ONE_Q    = word_t'(1) <<< FRAC;
    localparam word_t TWO_Q    = ONE_Q <<< 1;
    localparam word_t WORD_MAX = 32'sh7fff_ffff;
    localparam word_t WORD_MIN = 32'sh8000_0000;

    // Full-width product, add half an LSB, floor shift, keep the low word.
    function automatic word_t fx_mul(word_t a, word_t b);
        longint prod;
        prod = longint'(a) * longint'(b) + (longint'(1) <<< (FRAC - 1));
        return word_t'(prod >>> FRAC);
    endfunction

    function automatic quat_res_t predict_quat(quat_op_t op);
        quat_res_t res;
        word_t     xx, yy, zz, xy, yz, xz, wx, wy, wz;
        res = '0;
        case (op.cmd)
            qfpu_pkg::CMD_ADD: begin
                res[0] = op.aw + op.bw;
                res[1] = op.ax + op.bx;
                res[2] = op.ay + op.by;
                res[3] = op.az + op.bz;
            end
            qfpu_pkg::CMD_SUB: begin
                res[0] = op.aw - op.bw;
                res[1] = op.ax - op.bx;
                res[2] = op.ay - op.by;
                res[3] = op.az - op.bz;
            end
            qfpu_pkg::CMD_MUL: begin
                // cross terms negated: this is b * a in the usual Hamilton order
                res[0] = fx_mul(op.aw, op.bw) - fx_mul(op.ax, op.bx)
                       - fx_mul(op.ay, op.by) - fx_mul(op.az, op.bz);
                res[1] = fx_mul(op.aw, op.bx) + fx_mul(op.ax, op.bw)
                       - fx_mul(op.ay, op.bz) + fx_mul(op.az, op.by);
                res[2] = fx_mul(op.aw, op.by) + fx_mul(op.ax, op.bz)
                       + fx_mul(op.ay, op.bw) - fx_mul(op.az, op.bx);
                res[3] = fx_mul(op.aw, op.bz) - fx_mul(op.ax, op.by)
                       + fx_mul(op.ay, op.bx) + fx_mul(op.az, op.bw);
            end
            qfpu_pkg::CMD_SCALE: begin
                res[0] = fx_mul(op.sc, op.aw);
                res[1] = fx_mul(op.sc, op.ax);
                res[2] = fx_mul(op.sc, op.ay);
                res[3] = fx_mul(op.sc, op.az);
            end
            qfpu_pkg::CMD_NORM: begin
                res[0] = fx_mul(op.aw, op.aw) + fx_mul(op.ax, op.ax)
                       + fx_mul(op.ay, op.ay) + fx_mul(op.az, op.az);
            end
            qfpu_pkg::CMD_ROT: begin
                xx = fx_mul(op.ax, op.ax);
                yy = fx_mul(op.ay, op.ay);
                zz = fx_mul(op.az, op.az);
                xy = fx_mul(op.ax, op.ay);
                yz = fx_mul(op.ay, op.az);
                xz = fx_mul(op.ax, op.az);
                wx = fx_mul(op.aw, op.ax);
                wy = fx_mul(op.aw, op.ay);
                wz = fx_mul(op.aw, op.az);
                res[0] = ONE_Q - fx_mul(TWO_Q, word_t'(yy + zz));
                res[1] = fx_mul(TWO_Q, word_t'(xy - wz));
                res[2] = fx_mul(TWO_Q, word_t'(xz + wy));
                res[3] = fx_mul(TWO_Q, word_t'(xy + wz));
                res[4] = ONE_Q - fx_mul(TWO_Q, word_t'(zz + xx));
                res[5] = fx_mul(TWO_Q, word_t'(yz - wx));
                res[6] = fx_mul(TWO_Q, word_t'(xz - wy));
                res[7] = fx_mul(TWO_Q, word_t'(yz + wx));
                res[8] = ONE_Q - fx_mul(TWO_Q, word_t'(yy + xx));
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic quat_op_t mk_op(logic [qfpu_pkg::CMD_W-1:0] cmd,
                                       word_t aw, word_t ax, word_t ay, word_t az,
                                       word_t bw, word_t bx, word_t by, word_t bz,
                                       word_t sc);
        quat_op_t op;
        op.cmd = cmd;
        op.aw  = aw;
        op.ax  = ax;
        op.ay  = ay;
        op.az  = az;
        op.bw  = bw;
        op.bx  = bx;
        op.by  = by;
        op.bz  = bz;
        op.sc  = sc;
        return op;
    endfunction

    // Mix of full-range words, small Q values, unit-range values, edge values and right-shifted random words.
    function automatic word_t rand_word();
        word_t val;
        int    pick;
        pick = $urandom_range(0, 9);
        if (pick <= 3) begin
            val = word_t'($urandom);
        end else if (pick <= 6) begin
            val = word_t'($urandom_range(0, 65536)) - 32768;
        end else if (pick == 7) begin
            val = word_t'($urandom_range(0, 2 * ONE_Q)) - ONE_Q;
        end else if (pick == 8) begin
            case ($urandom_range(0, 5))
                0: val = WORD_MAX;
                1: val = WORD_MIN;
                2: val = '0;
                3: val = -1;
                4: val = ONE_Q;
                default: val = -ONE_Q;
            endcase
        end else begin
            val = $signed($urandom) >>> $urandom_range(0, 31);
        end
        return val;
    endfunction

    function automatic quat_op_t rand_quat_op();
        logic [qfpu_pkg::CMD_W-1:0] cmd;
        if ($urandom_range(0, 49) == 0)
            cmd = 3'($urandom_range(CMD_SPARE6, CMD_SPARE7));
        else
            cmd = 3'($urandom_range(qfpu_pkg::CMD_ADD, qfpu_pkg::CMD_ROT));
        return mk_op(cmd, rand_word(), rand_word(), rand_word(), rand_word(),
                     rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
    endfunction

    class quat_scoreboard;
        quat_res_t pending_results[$];
        int        mismatches = 0;
        int        checked = 0;

        function void note_input(quat_op_t op);
            pending_results.push_back(predict_quat(op));
        endfunction

        function void check_result(quat_res_t got);
            quat_res_t want;
            int        i;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result transaction with nothing outstanding, expected none, got r0 0x%08h",
                         $time, got[0]);
                return;
            end
            want = pending_results.pop_front();
            for (i = 0; i < qfpu_pkg::NUM_RES; i++) begin
                if (want[i] !== got[i]) begin
                    mismatches++;
                    $display("%0t: result %0d field r%0d expected %0d (0x%08h)",
                             $time, checked, i, $signed(want[i]), want[i]);
                    $display("%0t:     got %0d (0x%08h)", $time, $signed(got[i]), got[i]);
                end
            end
            checked++;
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction
    endclass

endpackage

@@ tb/sv/quaternion_fixed_point_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the quaternion fixed-point unit with random handshake gaps.
module quaternion_fixed_point_unit_tb;
    import qfpu_pkg::*;
    import qfpu_tb_pkg::*;

    localparam int RANDOM_OPS    = 1250;
    localparam int PAUSE_AT      = 600;
    localparam int STALL_LIMIT   = 200;
    localparam int SETTLE_CYCLES = 20;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [CMD_W-1:0] s_cmd = '0;
    word_t            s_a_w = '0;
    word_t            s_a_x = '0;
    word_t            s_a_y = '0;
    word_t            s_a_z = '0;
    word_t            s_b_w = '0;
    word_t            s_b_x = '0;
    word_t            s_b_y = '0;
    word_t            s_b_z = '0;
    word_t            s_scale = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    word_t            m_r0, m_r1, m_r2, m_r3, m_r4, m_r5, m_r6, m_r7, m_r8;

    quat_scoreboard   sb = new();
    bit               no_gaps = 1'b0;
    int               idle_cycles = 0;
    int               ops_seen[8];
    int               ops_total = 0;

    quaternion_fixed_point_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .s_a_w   (s_a_w),
        .s_a_x   (s_a_x),
        .s_a_y   (s_a_y),
        .s_a_z   (s_a_z),
        .s_b_w   (s_b_w),
        .s_b_x   (s_b_x),
        .s_b_y   (s_b_y),
        .s_b_z   (s_b_z),
        .s_scale (s_scale),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_r0    (m_r0),
        .m_r1    (m_r1),
        .m_r2    (m_r2),
        .m_r3    (m_r3),
        .m_r4    (m_r4),
        .m_r5    (m_r5),
        .m_r6    (m_r6),
        .m_r7    (m_r7),
        .m_r8    (m_r8)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // End the run if neither channel moves a transaction for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("[quaternion_fixed_point_unit] ERROR");
                $finish;
            end
        end
    end

    task automatic send_op(input quat_op_t op);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd   <= op.cmd;
        s_a_w   <= op.aw;
        s_a_x   <= op.ax;
        s_a_y   <= op.ay;
        s_a_z   <= op.az;
        s_b_w   <= op.bw;
        s_b_x   <= op.bx;
        s_b_y   <= op.by;
        s_b_z   <= op.bz;
        s_scale <= op.sc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(op);
        ops_seen[op.cmd]++;
        ops_total++;
    endtask

    // Drop valid and hold off until every outstanding result has come back.
    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending_count() != 0) @(negedge aclk);
    endtask

    task automatic collect_results();
        int        gap;
        quat_res_t got;
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 3);
            @(negedge aclk);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got = {m_r8, m_r7, m_r6, m_r5, m_r4, m_r3, m_r2, m_r1, m_r0};
            sb.check_result(got);
        end
    endtask

    initial begin
        wait (aresetn === 1'b1);
        collect_results();
    end

    initial begin
        int k;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: wraparound, rounding boundaries, identities and spare opcodes
        send_op(mk_op(CMD_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_op(mk_op(CMD_ADD, WORD_MAX, WORD_MAX, WORD_MIN, -1,
                      1, WORD_MAX, WORD_MIN, -1, WORD_MAX));
        send_op(mk_op(CMD_SUB, WORD_MIN, 0, WORD_MAX, -1,
                      1, WORD_MIN, -1, WORD_MAX, WORD_MIN));
        send_op(mk_op(CMD_MUL, ONE_Q, 0, 0, 0, 123456, -77777, WORD_MAX, WORD_MIN, 0));
        send_op(mk_op(CMD_MUL, 0, ONE_Q, 0, 0, 0, 0, ONE_Q, 0, -1));
        send_op(mk_op(CMD_MUL, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN,
                      WORD_MIN, WORD_MAX, -1, WORD_MAX, 0));
        send_op(mk_op(CMD_MUL, 1, -1, -1, 1, 2048, 2048, 2049, 2047, 0));
        send_op(mk_op(CMD_SCALE, WORD_MAX, WORD_MIN, -1, 1, 0, 0, 0, 0, ONE_Q));
        send_op(mk_op(CMD_SCALE, WORD_MIN, WORD_MAX, ONE_Q, -ONE_Q, 0, 0, 0, 0, WORD_MIN));
        send_op(mk_op(CMD_SCALE, 2048, -2048, 2049, -2049, 0, 0, 0, 0, 1));
        send_op(mk_op(CMD_SCALE, WORD_MAX, -5, 77, WORD_MIN, -1, -1, -1, -1, 0));
        send_op(mk_op(CMD_SCALE, 2048, -2048, ONE_Q, 3, 0, 0, 0, 0, -1));
        send_op(mk_op(CMD_NORM, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 0, 0, 0, 0, 0));
        send_op(mk_op(CMD_NORM, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, -1, -1, -1, -1, -1));
        send_op(mk_op(CMD_NORM, 2048, 2048, 2048, 2048, 0, 0, 0, 0, 0));
        send_op(mk_op(CMD_ROT, ONE_Q, 0, 0, 0, 0, 0, 0, 0, 0));
        send_op(mk_op(CMD_ROT, 2896, 0, 0, 2896, 0, 0, 0, 0, 0));
        send_op(mk_op(CMD_ROT, 0, ONE_Q, 0, 0, 0, 0, 0, 0, 0));
        send_op(mk_op(CMD_ROT, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, 0, 0, 0, 0, 0));
        send_op(mk_op(CMD_ROT, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        send_op(mk_op(CMD_SPARE6, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                      WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
        send_op(mk_op(CMD_SPARE7, WORD_MIN, -1, ONE_Q, 5, WORD_MIN, -1, ONE_Q, 5, WORD_MIN));

        // random: every fourth block of 100 runs with both sides at full rate
        for (k = 0; k < RANDOM_OPS; k++) begin
            no_gaps = ((k / 100) % 4) == 3;
            if (k == PAUSE_AT)
                wait_for_drain();
            send_op(rand_quat_op());
        end
        no_gaps = 1'b0;

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Checked %0d results from %0d input transactions, %0d field mismatches",
                 sb.checked, ops_total, sb.mismatches);
        $display("Opcode mix: add %0d sub %0d mul %0d scale %0d norm %0d rot %0d spare %0d",
                 ops_seen[CMD_ADD], ops_seen[CMD_SUB], ops_seen[CMD_MUL],
                 ops_seen[CMD_SCALE], ops_seen[CMD_NORM], ops_seen[CMD_ROT],
                 ops_seen[CMD_SPARE6] + ops_seen[CMD_SPARE7]);
        if (sb.mismatches == 0 && sb.pending_count() == 0)
            $display("[quaternion_fixed_point_unit] OK");
        else
            $display("[quaternion_fixed_point_unit] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/qfpu_pkg.sv
hdl/qfpu_opsel.sv
hdl/qfpu_fmul.sv
hdl/qfpu_combine.sv
hdl/quaternion_fixed_point_unit.sv
hdl/qfpu_checker.sv
tb/sv/qfpu_tb_pkg.sv
tb/sv/quaternion_fixed_point_unit_tb.sv
